>>> rtl/fbpw_pkg.sv
// Shared types, constants and register codes of the framebuffer pixel writer.
package fbpw_pkg;

	// Field widths
	localparam int COORD_BITS  = 12;
	localparam int STRIDE_BITS = 16;
	localparam int OFFSET_BITS = COORD_BITS + STRIDE_BITS;
	localparam int LEVEL_BITS  = 8;
	localparam int WORD_BITS   = 32;
	localparam int BPP_BITS    = 6;
	localparam int SIZE_BITS   = 4;
	localparam int SHIFT_BITS  = 5;
	localparam int KIND_BITS   = 2;
	localparam int BYTES_BITS  = 4;

	// Configuration port: the data bus is as wide as the widest register.
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = STRIDE_BITS;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_STRIDE    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_DEPTH    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RED_SIZE       = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RED_SHIFT      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_SIZE     = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_SHIFT    = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_SIZE      = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_SHIFT     = 3'd7;

	// Supported pixel depths
	localparam logic [BPP_BITS-1:0] BPP_8  = 6'd8;
	localparam logic [BPP_BITS-1:0] BPP_14 = 6'd14;
	localparam logic [BPP_BITS-1:0] BPP_15 = 6'd15;
	localparam logic [BPP_BITS-1:0] BPP_16 = 6'd16;
	localparam logic [BPP_BITS-1:0] BPP_24 = 6'd24;
	localparam logic [BPP_BITS-1:0] BPP_32 = 6'd32;

	// Write width codes
	localparam logic [KIND_BITS-1:0] KIND_NONE     = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_BYTE     = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_HALFWORD = 2'd2;
	localparam logic [KIND_BITS-1:0] KIND_WORD     = 2'd3;

	// Channel size at which the full 8-bit channel is kept
	localparam logic [SIZE_BITS-1:0] SIZE_FULL = 4'd8;

	// Register contents after reset
	localparam logic [STRIDE_BITS-1:0] RST_LINE_STRIDE    = '0;
	localparam logic [BPP_BITS-1:0]    RST_PIXEL_DEPTH    = BPP_32;
	localparam logic [SIZE_BITS-1:0]   RST_SIZE           = SIZE_FULL;
	localparam logic [SHIFT_BITS-1:0]  RST_RED_SHIFT      = 5'd16;
	localparam logic [SHIFT_BITS-1:0]  RST_GREEN_SHIFT    = 5'd8;
	localparam logic [SHIFT_BITS-1:0]  RST_BLUE_SHIFT     = 5'd0;

	// One colour channel's layout in the pixel word
	typedef struct packed {
		logic [SIZE_BITS-1:0]  size;
		logic [SHIFT_BITS-1:0] shift;
	} chan_fmt_t;

	// Complete configuration as seen by the datapath
	typedef struct packed {
		logic [STRIDE_BITS-1:0] line_stride;
		logic [BPP_BITS-1:0]    pixel_depth;
		chan_fmt_t              red;
		chan_fmt_t              green;
		chan_fmt_t              blue;
	} cfg_t;

endpackage

>>> rtl/fbpw_cfg_regs.sv
// Configuration register file of the framebuffer pixel writer.
module fbpw_cfg_regs
	import fbpw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// Each write lands in the register named by the index, low bits kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_stride    <= RST_LINE_STRIDE;
			cfg_q.pixel_depth    <= RST_PIXEL_DEPTH;
			cfg_q.red.size       <= RST_SIZE;
			cfg_q.red.shift      <= RST_RED_SHIFT;
			cfg_q.green.size     <= RST_SIZE;
			cfg_q.green.shift    <= RST_GREEN_SHIFT;
			cfg_q.blue.size      <= RST_SIZE;
			cfg_q.blue.shift     <= RST_BLUE_SHIFT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_STRIDE:    cfg_q.line_stride    <= cfg_data[STRIDE_BITS-1:0];
				REG_PIXEL_DEPTH:    cfg_q.pixel_depth    <= cfg_data[BPP_BITS-1:0];
				REG_RED_SIZE:       cfg_q.red.size       <= cfg_data[SIZE_BITS-1:0];
				REG_RED_SHIFT:      cfg_q.red.shift      <= cfg_data[SHIFT_BITS-1:0];
				REG_GREEN_SIZE:     cfg_q.green.size     <= cfg_data[SIZE_BITS-1:0];
				REG_GREEN_SHIFT:    cfg_q.green.shift    <= cfg_data[SHIFT_BITS-1:0];
				REG_BLUE_SIZE:      cfg_q.blue.size      <= cfg_data[SIZE_BITS-1:0];
				REG_BLUE_SHIFT:     cfg_q.blue.shift     <= cfg_data[SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/fbpw_colour_pack.sv
// Colour ramp and pixel word packing of the framebuffer pixel writer.
module fbpw_colour_pack
	import fbpw_pkg::*;
(
	input  logic [LEVEL_BITS-1:0] level,
	input  chan_fmt_t             red_fmt,
	input  chan_fmt_t             green_fmt,
	input  chan_fmt_t             blue_fmt,
	output logic [WORD_BITS-1:0]  pixel_word
);

	// Keep the top bits of a channel and move them to their place in the word.
	// Shifting the 8-bit channel right by (8 - size) leaves exactly size bits.
	function automatic logic [WORD_BITS-1:0] place_channel(
		input logic [LEVEL_BITS-1:0] chan,
		input chan_fmt_t             fmt
	);
		logic [SIZE_BITS-1:0]  size_sat;
		logic [SIZE_BITS-1:0]  drop;
		logic [LEVEL_BITS-1:0] kept;
		size_sat = (fmt.size > SIZE_FULL) ? SIZE_FULL : fmt.size;
		drop     = SIZE_FULL - size_sat;
		kept     = chan >> drop;
		return {{(WORD_BITS-LEVEL_BITS){1'b0}}, kept} << fmt.shift;
	endfunction

	logic [LEVEL_BITS-1:0] red;
	logic [LEVEL_BITS-1:0] green;
	logic [LEVEL_BITS-1:0] blue;

	// Ramp: red follows the level, green falls as it rises, blue is half of it.
	assign red   = level;
	assign green = ~level;
	assign blue  = level >> 1;

	assign pixel_word = place_channel(red, red_fmt)
	                  | place_channel(green, green_fmt)
	                  | place_channel(blue, blue_fmt);

endmodule

>>> rtl/fbpw_addr_gen.sv
// Write width decode and byte offset calculation of the framebuffer pixel writer.
module fbpw_addr_gen
	import fbpw_pkg::*;
(
	input  logic [COORD_BITS-1:0]  column,
	input  logic [COORD_BITS-1:0]  row,
	input  logic [STRIDE_BITS-1:0] line_stride,
	input  logic [BPP_BITS-1:0]    pixel_depth,
	output logic [OFFSET_BITS-1:0] byte_offset,
	output logic [KIND_BITS-1:0]   write_kind
);

	logic [BPP_BITS:0]              bpp_round;
	logic [BYTES_BITS-1:0]          bytes_pp;
	logic [OFFSET_BITS-1:0]         line_part;
	logic [COORD_BITS+BYTES_BITS-1:0] column_part;
	logic [OFFSET_BITS:0]           offset_sum;

	// Pixel depth decides the width of the memory write.
	always_comb begin
		unique case (pixel_depth) inside
			BPP_8:                  write_kind = KIND_BYTE;
			BPP_14, BPP_15, BPP_16: write_kind = KIND_HALFWORD;
			BPP_24, BPP_32:         write_kind = KIND_WORD;
			default:                write_kind = KIND_NONE;
		endcase
	end

	// Bytes per pixel is the depth rounded up to whole bytes.
	assign bpp_round = {1'b0, pixel_depth} + (BPP_BITS+1)'(7);
	assign bytes_pp  = bpp_round[BPP_BITS:3];

	// Row times stride plus column times bytes per pixel, wrapped to the offset width.
	assign line_part   = row * line_stride;
	assign column_part = column * bytes_pp;
	assign offset_sum  = {1'b0, line_part}
	                   + (OFFSET_BITS+1)'(column_part);

	assign byte_offset = (write_kind == KIND_NONE) ? '0 : offset_sum[OFFSET_BITS-1:0];

endmodule

>>> rtl/framebuffer_pixel_writer_top.sv
// Framebuffer pixel writer: request register, colour and address logic, result register.
// A request accepted into the request register passes through the colour and address logic
// into the result register, whose valid flag drives done.
// Throughput: one request per cycle; busy stays low, so start may be held high.
// Each result is shown with done for one cycle; the receiver cannot stall it.
// Reset (arst_n low) clears both pipeline valid flags and restores register defaults.
module framebuffer_pixel_writer_top
	import fbpw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [COORD_BITS-1:0]     column,
	input  logic [COORD_BITS-1:0]     row,
	input  logic [LEVEL_BITS-1:0]     level,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output logic                      done,
	output logic [OFFSET_BITS-1:0]    byte_offset,
	output logic [WORD_BITS-1:0]      pixel_word,
	output logic [KIND_BITS-1:0]      write_kind
);

	cfg_t                   cfg;
	logic                   accept;
	logic                   valid_s1;
	logic [COORD_BITS-1:0]  column_s1;
	logic [COORD_BITS-1:0]  row_s1;
	logic [LEVEL_BITS-1:0]  level_s1;
	logic [WORD_BITS-1:0]   packed_word;
	logic [OFFSET_BITS-1:0] offset_calc;
	logic [KIND_BITS-1:0]   kind_calc;
	logic                   valid_s2;
	logic [OFFSET_BITS-1:0] byte_offset_s2;
	logic [WORD_BITS-1:0]   pixel_word_s2;
	logic [KIND_BITS-1:0]   write_kind_s2;

	// The pipeline never holds back a request.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	fbpw_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			column_s1 <= column;
			row_s1    <= row;
			level_s1  <= level;
		end
	end

	fbpw_colour_pack u_colour_pack (
		.level      (level_s1),
		.red_fmt    (cfg.red),
		.green_fmt  (cfg.green),
		.blue_fmt   (cfg.blue),
		.pixel_word (packed_word)
	);

	fbpw_addr_gen u_addr_gen (
		.column      (column_s1),
		.row         (row_s1),
		.line_stride (cfg.line_stride),
		.pixel_depth (cfg.pixel_depth),
		.byte_offset (offset_calc),
		.write_kind  (kind_calc)
	);

	// Result register; an unsupported depth gives an all-zero result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			byte_offset_s2 <= offset_calc;
			pixel_word_s2  <= (kind_calc == KIND_NONE) ? '0 : packed_word;
			write_kind_s2  <= kind_calc;
		end
	end

	assign done        = valid_s2;
	assign byte_offset = byte_offset_s2;
	assign pixel_word  = pixel_word_s2;
	assign write_kind  = write_kind_s2;

endmodule

>>> rtl/fbpw_checker.sv
// Port-level checks of the framebuffer pixel writer and their binding to the top level.
module fbpw_checker
	import fbpw_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic [OFFSET_BITS-1:0] byte_offset,
	input logic [WORD_BITS-1:0]   pixel_word,
	input logic [KIND_BITS-1:0]   write_kind
);

	// Every accepted request yields a result once it has passed the request and result registers.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted request gave no result two cycles later");

	// No result appears without a matching request accepted before it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching request");

	// An unsupported depth gives an all-zero result.
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (write_kind == KIND_NONE) |-> (byte_offset == '0) && (pixel_word == '0))
		else $error("unsupported depth gave a non-zero result");

endmodule

bind framebuffer_pixel_writer_top fbpw_checker u_fbpw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.byte_offset (byte_offset),
	.pixel_word  (pixel_word),
	.write_kind  (write_kind)
);

>>> verif/framebuffer_pixel_writer_top_test.sv
// Self-checking testbench for the framebuffer pixel writer top level.
module framebuffer_pixel_writer_top_test;
	import fbpw_pkg::*;

	// One framebuffer write as the block should report it
	typedef struct {
		logic [OFFSET_BITS-1:0] byte_offset;
		logic [WORD_BITS-1:0]   pixel_word;
		logic [KIND_BITS-1:0]   write_kind;
	} pixel_write_t;

	// Keeps a shadow of the registers, predicts each write and checks the block's results.
	class pixel_write_scoreboard;
		cfg_t         layout;
		pixel_write_t expected_writes[$];
		int unsigned  mismatches;

		function void restore_defaults();
			layout.line_stride    = RST_LINE_STRIDE;
			layout.pixel_depth    = RST_PIXEL_DEPTH;
			layout.red            = '{size: RST_SIZE, shift: RST_RED_SHIFT};
			layout.green          = '{size: RST_SIZE, shift: RST_GREEN_SHIFT};
			layout.blue           = '{size: RST_SIZE, shift: RST_BLUE_SHIFT};
			expected_writes.delete();
			mismatches = 0;
		endfunction

		// Each register keeps only the low bits of the data bus that it is wide.
		function void set_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
			case (index)
				REG_LINE_STRIDE:    layout.line_stride    = data[STRIDE_BITS-1:0];
				REG_PIXEL_DEPTH:    layout.pixel_depth    = data[BPP_BITS-1:0];
				REG_RED_SIZE:       layout.red.size       = data[SIZE_BITS-1:0];
				REG_RED_SHIFT:      layout.red.shift      = data[SHIFT_BITS-1:0];
				REG_GREEN_SIZE:     layout.green.size     = data[SIZE_BITS-1:0];
				REG_GREEN_SHIFT:    layout.green.shift    = data[SHIFT_BITS-1:0];
				REG_BLUE_SIZE:      layout.blue.size      = data[SIZE_BITS-1:0];
				REG_BLUE_SHIFT:     layout.blue.shift     = data[SHIFT_BITS-1:0];
				default: ;
			endcase
		endfunction

		// Keeps the top bits of a channel and moves them to their place; bits past 31 are lost.
		function logic [WORD_BITS-1:0] place_channel(logic [7:0] chan, chan_fmt_t fmt);
			int unsigned    kept_bits;
			logic [7:0]     kept;
			logic [63:0]    wide;
			kept_bits = (fmt.size > SIZE_FULL) ? 8 : fmt.size;
			if (kept_bits == 0)
				return '0;
			kept = chan >> (8 - kept_bits);
			wide = 64'(kept) << fmt.shift;
			return wide[WORD_BITS-1:0];
		endfunction

		// Works out the write that one request should cause and queues it.
		function void note_request(logic [COORD_BITS-1:0] column, logic [COORD_BITS-1:0] row,
				logic [LEVEL_BITS-1:0] level);
			pixel_write_t  wr;
			int unsigned   pixel_bytes;
			logic [63:0]   offset;
			logic [7:0]    green;
			case (layout.pixel_depth)
				BPP_8:                  wr.write_kind = KIND_BYTE;
				BPP_14, BPP_15, BPP_16: wr.write_kind = KIND_HALFWORD;
				BPP_24, BPP_32:         wr.write_kind = KIND_WORD;
				default:                wr.write_kind = KIND_NONE;
			endcase
			if (wr.write_kind == KIND_NONE) begin
				wr.byte_offset = '0;
				wr.pixel_word  = '0;
			end else begin
				green = 8'd255 - level;
				wr.pixel_word = place_channel(level, layout.red)
					| place_channel(green, layout.green)
					| place_channel(level >> 1, layout.blue);
				pixel_bytes = (int'(layout.pixel_depth) + 7) >> 3;
				offset = 64'(row) * 64'(layout.line_stride) + 64'(column) * 64'(pixel_bytes);
				wr.byte_offset = offset[OFFSET_BITS-1:0];
			end
			expected_writes.push_back(wr);
		endfunction

		// Compares one result with the oldest write still expected.
		function void check_result(logic [OFFSET_BITS-1:0] byte_offset,
				logic [WORD_BITS-1:0] pixel_word, logic [KIND_BITS-1:0] write_kind);
			pixel_write_t wr;
			if (expected_writes.size() == 0) begin
				$error("result with no request outstanding: offset %0h word %0h kind %0d",
					byte_offset, pixel_word, write_kind);
				mismatches++;
				return;
			end
			wr = expected_writes.pop_front();
			if (byte_offset !== wr.byte_offset) begin
				$error("byte_offset: expected %0h, got %0h", wr.byte_offset, byte_offset);
				mismatches++;
			end
			if (pixel_word !== wr.pixel_word) begin
				$error("pixel_word: expected %0h, got %0h", wr.pixel_word, pixel_word);
				mismatches++;
			end
			if (write_kind !== wr.write_kind) begin
				$error("write_kind: expected %0d, got %0d", wr.write_kind, write_kind);
				mismatches++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_REQUESTS = 50;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [COORD_BITS-1:0]     column = '0;
	logic [COORD_BITS-1:0]     row = '0;
	logic [LEVEL_BITS-1:0]     level = '0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      done;
	logic [OFFSET_BITS-1:0]    byte_offset;
	logic [WORD_BITS-1:0]      pixel_word;
	logic [KIND_BITS-1:0]      write_kind;

	pixel_write_scoreboard sb = new();
	bit  gaps_enabled = 1'b1;
	int  stall_cycles = 0;

	framebuffer_pixel_writer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.column(column),
		.row(row),
		.level(level),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.byte_offset(byte_offset),
		.pixel_word(pixel_word),
		.write_kind(write_kind)
	);

	always #5 clk = ~clk;

	// Requests and results are both sampled at the edge that accepts them.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_request(column, row, level);
		if (arst_n && done)
			sb.check_result(byte_offset, pixel_word, write_kind);
	end

	// Ends the run if neither side makes progress for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Presents one request and holds it until the block takes it; start stays high afterwards.
	task automatic send_pixel(int unsigned x, int unsigned y, int unsigned value);
		if (gaps_enabled && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		column <= x[COORD_BITS-1:0];
		row    <= y[COORD_BITS-1:0];
		level  <= value[LEVEL_BITS-1:0];
		do @(posedge clk); while (busy);
	endtask

	// Stops requesting and waits until every queued write has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_writes.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes one register; bus bits above the register's width carry random junk.
	task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] index, int unsigned value,
			int unsigned width);
		int unsigned junk;
		junk = $urandom_range(0, 65535);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= CFG_DATA_BITS'(((junk >> width) << width) | value);
		@(posedge clk);
		sb.set_reg(index, CFG_DATA_BITS'(((junk >> width) << width) | value));
	endtask

	// Rewrites the whole pixel layout once the block is idle.
	task automatic set_layout(int unsigned stride, int unsigned bpp,
			int unsigned rsz, int unsigned rsh, int unsigned gsz, int unsigned gsh,
			int unsigned bsz, int unsigned bsh);
		drain();
		cfg_write(REG_LINE_STRIDE, stride, STRIDE_BITS);
		cfg_write(REG_PIXEL_DEPTH, bpp, BPP_BITS);
		cfg_write(REG_RED_SIZE, rsz, SIZE_BITS);
		cfg_write(REG_RED_SHIFT, rsh, SHIFT_BITS);
		cfg_write(REG_GREEN_SIZE, gsz, SIZE_BITS);
		cfg_write(REG_GREEN_SHIFT, gsh, SHIFT_BITS);
		cfg_write(REG_BLUE_SIZE, bsz, SIZE_BITS);
		cfg_write(REG_BLUE_SHIFT, bsh, SHIFT_BITS);
		cfg_we <= 1'b0;
	endtask

	// Changes only the pixel depth once the block is idle.
	task automatic set_depth(int unsigned bpp);
		drain();
		cfg_write(REG_PIXEL_DEPTH, bpp, BPP_BITS);
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned pick_coord();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return 0;
		if (roll < 20)
			return (1 << COORD_BITS) - 1;
		return $urandom_range(0, (1 << COORD_BITS) - 1);
	endfunction

	function automatic int unsigned pick_size();
		if ($urandom_range(0, 99) < 70)
			return $urandom_range(1, 8);
		return $urandom_range(0, 15);
	endfunction

	function automatic int unsigned pick_depth();
		int unsigned depths[6];
		depths = '{8, 14, 15, 16, 24, 32};
		if ($urandom_range(0, 99) < 85)
			return depths[$urandom_range(0, 5)];
		return $urandom_range(0, 63);
	endfunction

	function automatic int unsigned pick_stride();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return 0;
		if (roll < 20)
			return 65535;
		return $urandom_range(0, 65535);
	endfunction

	// Main sequence: reset, directed cases, then random layouts with random pixels.
	initial begin
		sb.restore_defaults();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset layout: 32-bit pixels, zero stride.
		send_pixel(0, 0, 0);
		send_pixel(4095, 4095, 255);

		// Widest stride, red at the top bit so that its upper bits fall off,
		// an oversized green size and an empty blue channel.
		set_layout(65535, 32, 8, 31, 15, 28, 0, 0);
		send_pixel(4095, 4095, 255);
		send_pixel(0, 4095, 128);
		send_pixel(4095, 0, 1);

		// Byte-wide pixels with narrow channels.
		set_layout(1, 8, 1, 0, 3, 1, 4, 4);
		send_pixel(1, 1, 8'h55);
		send_pixel(4095, 4095, 8'hAA);

		// Halfword depths and the 24-bit depth that still writes a word.
		set_depth(14);
		send_pixel(10, 20, 8'h7F);
		set_depth(15);
		send_pixel(4095, 1, 8'h80);
		set_depth(16);
		send_pixel(2730, 1365, 8'hFE);
		set_depth(24);
		send_pixel(4095, 4095, 200);

		// Unsupported depths give no write at all.
		set_depth(0);
		send_pixel(4095, 4095, 255);
		set_depth(63);
		send_pixel(1365, 2730, 8'h33);
		set_depth(7);
		send_pixel(5, 6, 9);

		// Random layouts; the middle phases run without any gaps.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_layout(pick_stride(), pick_depth(), pick_size(), $urandom_range(0, 31),
				pick_size(), $urandom_range(0, 31), pick_size(), $urandom_range(0, 31));
			gaps_enabled = !(phase >= 6 && phase < 10);
			for (int n = 0; n < PHASE_REQUESTS; n++)
				send_pixel(pick_coord(), pick_coord(), $urandom_range(0, 255));
		end

		drain();
		if (sb.mismatches == 0 && sb.expected_writes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
